[hdl/lqr_step_with_harmonic_disturbance_macros.svh]
// Assertion macros shared by the LQR step block
`ifndef LQR_STEP_WITH_HARMONIC_DISTURBANCE_MACROS_SVH
`define LQR_STEP_WITH_HARMONIC_DISTURBANCE_MACROS_SVH

`ifndef NO_ASSERTIONS
`define LQRHD_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("lqrhd assertion failed");
`define LQRHD_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lqrhd implication failed");
`else
`define LQRHD_ASSERT(label, prop)
`define LQRHD_ASSERT_IMPL(label, ante, cons)
`endif

`endif

[hdl/lqrhd_pkg.sv]
// Types, constants and fixed-point helpers for the LQR step block
`timescale 1ns / 1ps
package lqrhd_pkg;

   localparam int DATA_W     = 32;
   localparam int FRAC_SHIFT = 24;
   localparam int PROD_W     = 2 * DATA_W - FRAC_SHIFT;
   localparam int SUM_W      = PROD_W + 4;
   localparam int REG_IDX_W  = 3;

   localparam logic [DATA_W-1:0] DIAG_RESET = DATA_W'(32'h0100_0000);
   localparam logic [DATA_W-1:0] SAT_MAX    = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic [DATA_W-1:0] SAT_MIN    = {1'b1, {(DATA_W-1){1'b0}}};

   typedef enum logic [REG_IDX_W-1:0] {
      REG_DIAG_COEF          = 3'd0,
      REG_UPPER_COEF         = 3'd1,
      REG_LOWER_COEF         = 3'd2,
      REG_GAIN_POSITION      = 3'd3,
      REG_GAIN_RATE          = 3'd4,
      REG_GAIN_DIST_POSITION = 3'd5,
      REG_GAIN_DIST_RATE     = 3'd6,
      REG_GAIN_DRIVE         = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic [DATA_W-1:0] diag_coef;
      logic [DATA_W-1:0] upper_coef;
      logic [DATA_W-1:0] lower_coef;
      logic [DATA_W-1:0] gain_position;
      logic [DATA_W-1:0] gain_rate;
      logic [DATA_W-1:0] gain_dist_position;
      logic [DATA_W-1:0] gain_dist_rate;
      logic [DATA_W-1:0] gain_drive;
   } coef_type;

   typedef struct packed {
      logic [DATA_W-1:0] drive;
      logic [DATA_W-1:0] dist_position;
      logic [DATA_W-1:0] dist_rate;
   } state_type;

   typedef struct packed {
      logic              clip;
      logic [DATA_W-1:0] value;
   } sat_type;

   // floor(coef * sig / 2^24)
   function automatic logic signed [PROD_W-1:0] mul_q24(input logic [DATA_W-1:0] coef,
                                                        input logic [DATA_W-1:0] sig);
      logic signed [2*DATA_W-1:0] prod;
      prod = $signed(coef) * $signed(sig);
      return $signed(prod[2*DATA_W-1:FRAC_SHIFT]);
   endfunction

   function automatic sat_type sat32(input logic signed [SUM_W-1:0] v);
      sat_type r;
      r.clip = !((&v[SUM_W-1:DATA_W-1]) || !(|v[SUM_W-1:DATA_W-1]));
      if (r.clip) begin
         r.value = v[SUM_W-1] ? SAT_MIN : SAT_MAX;
      end else begin
         r.value = v[DATA_W-1:0];
      end
      return r;
   endfunction

endpackage

[hdl/lqrhd_datapath.sv]
// Drive update and disturbance advance for one sample
`timescale 1ns / 1ps
module lqrhd_datapath (
   input  logic [lqrhd_pkg::DATA_W-1:0] position,
   input  logic [lqrhd_pkg::DATA_W-1:0] rate,
   input  logic                         restart,
   input  logic [lqrhd_pkg::DATA_W-1:0] seed_dist_position,
   input  logic [lqrhd_pkg::DATA_W-1:0] seed_dist_rate,
   input  lqrhd_pkg::coef_type          coef,
   input  lqrhd_pkg::state_type         state_cur,
   output lqrhd_pkg::state_type         state_next,
   output logic                         clipped
);
   import lqrhd_pkg::*;

   logic [DATA_W-1:0]        drive_cur;
   logic [DATA_W-1:0]        dpos_cur;
   logic [DATA_W-1:0]        drate_cur;
   logic signed [SUM_W-1:0]  fb_sum;
   logic signed [SUM_W-1:0]  drive_sum;
   logic signed [SUM_W-1:0]  dpos_sum;
   logic signed [SUM_W-1:0]  drate_sum;
   sat_type                  drive_sat;
   sat_type                  dpos_sat;
   sat_type                  drate_sat;

   always_comb begin
      drive_cur = restart ? '0 : state_cur.drive;
      dpos_cur  = restart ? seed_dist_position : state_cur.dist_position;
      drate_cur = restart ? seed_dist_rate : state_cur.dist_rate;

      fb_sum = SUM_W'(mul_q24(coef.gain_position, position))
             + SUM_W'(mul_q24(coef.gain_rate, rate))
             + SUM_W'(mul_q24(coef.gain_dist_position, dpos_cur))
             + SUM_W'(mul_q24(coef.gain_dist_rate, drate_cur))
             + SUM_W'(mul_q24(coef.gain_drive, drive_cur));
      drive_sum = SUM_W'($signed(drive_cur)) - fb_sum;

      // disturbance advance uses the pre-advance state
      dpos_sum  = SUM_W'(mul_q24(coef.diag_coef, dpos_cur))
                + SUM_W'(mul_q24(coef.upper_coef, drate_cur));
      drate_sum = SUM_W'(mul_q24(coef.lower_coef, dpos_cur))
                + SUM_W'(mul_q24(coef.diag_coef, drate_cur));

      drive_sat = sat32(drive_sum);
      dpos_sat  = sat32(dpos_sum);
      drate_sat = sat32(drate_sum);

      state_next.drive         = drive_sat.value;
      state_next.dist_position = dpos_sat.value;
      state_next.dist_rate     = drate_sat.value;
      clipped = drive_sat.clip | dpos_sat.clip | drate_sat.clip;
   end

endmodule

[hdl/lqr_step_with_harmonic_disturbance.sv]
// Discrete LQR state feedback with harmonic disturbance model: top level
//
// One transaction in, one transaction out. Accepted samples land in an input
// register; when the result register is free or read, the drive update and the
// disturbance advance are computed in parallel multipliers, summed, saturated
// and written to the state and result registers, flagged by rsp_valid. The
// sustained rate is one transaction per cycle while rsp_ready stays high; it
// is set by the state loop (multiply, sum, saturate, state register). A
// result waiting on rsp_ready stalls the stage, but a sample can still enter
// an empty input register. Restart seeds the disturbance state and clears
// the drive before that sample is processed. CSR writes take effect at once
// and are expected while no transaction is in flight.
`timescale 1ns / 1ps
`include "lqr_step_with_harmonic_disturbance_macros.svh"
module lqr_step_with_harmonic_disturbance (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [lqrhd_pkg::DATA_W-1:0] req_position,
   input  logic signed [lqrhd_pkg::DATA_W-1:0] req_rate,
   input  logic                                req_restart,
   input  logic signed [lqrhd_pkg::DATA_W-1:0] req_seed_dist_position,
   input  logic signed [lqrhd_pkg::DATA_W-1:0] req_seed_dist_rate,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [lqrhd_pkg::DATA_W-1:0] rsp_drive,
   output logic signed [lqrhd_pkg::DATA_W-1:0] rsp_dist_position_out,
   output logic signed [lqrhd_pkg::DATA_W-1:0] rsp_dist_rate_out,
   output logic                                rsp_saturated,
   input  logic                                csr_wen,
   input  logic [lqrhd_pkg::REG_IDX_W-1:0]     csr_index,
   input  logic [lqrhd_pkg::DATA_W-1:0]        csr_wdata
);
   import lqrhd_pkg::*;

   coef_type           coef_ff, coef_in;
   state_type          state_ff, state_in;
   logic               in_valid_ff, in_valid_in;
   logic               out_valid_ff, out_valid_in;
   logic [DATA_W-1:0]  pos_ff, rate_ff, seed_pos_ff, seed_rate_ff;
   logic               restart_ff;
   logic [DATA_W-1:0]  drive_out_ff, dpos_out_ff, drate_out_ff;
   logic               sat_out_ff;
   state_type          calc_state;
   logic               calc_clip;
   logic               in_fire;
   logic               stage_fire;
   logic               out_eq_state;

   assign stage_fire = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready  = !in_valid_ff || stage_fire;
   assign in_fire    = req_valid && req_ready;

   assign in_valid_in  = in_fire || (in_valid_ff && !stage_fire);
   assign out_valid_in = stage_fire || (out_valid_ff && !rsp_ready);
   assign state_in     = stage_fire ? calc_state : state_ff;

   always_comb begin
      coef_in = coef_ff;
      if (csr_wen) begin
         unique case (reg_index_type'(csr_index))
            REG_DIAG_COEF:          coef_in.diag_coef          = csr_wdata;
            REG_UPPER_COEF:         coef_in.upper_coef         = csr_wdata;
            REG_LOWER_COEF:         coef_in.lower_coef         = csr_wdata;
            REG_GAIN_POSITION:      coef_in.gain_position      = csr_wdata;
            REG_GAIN_RATE:          coef_in.gain_rate          = csr_wdata;
            REG_GAIN_DIST_POSITION: coef_in.gain_dist_position = csr_wdata;
            REG_GAIN_DIST_RATE:     coef_in.gain_dist_rate     = csr_wdata;
            REG_GAIN_DRIVE:         coef_in.gain_drive         = csr_wdata;
         endcase
      end
   end

   lqrhd_datapath u_datapath (
      .position           (pos_ff),
      .rate               (rate_ff),
      .restart            (restart_ff),
      .seed_dist_position (seed_pos_ff),
      .seed_dist_rate     (seed_rate_ff),
      .coef               (coef_ff),
      .state_cur          (state_ff),
      .state_next         (calc_state),
      .clipped            (calc_clip)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
         coef_ff      <= '{diag_coef: DIAG_RESET, default: '0};
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
         coef_ff      <= coef_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_fire) begin
         pos_ff       <= req_position;
         rate_ff      <= req_rate;
         restart_ff   <= req_restart;
         seed_pos_ff  <= req_seed_dist_position;
         seed_rate_ff <= req_seed_dist_rate;
      end
      if (stage_fire) begin
         drive_out_ff <= calc_state.drive;
         dpos_out_ff  <= calc_state.dist_position;
         drate_out_ff <= calc_state.dist_rate;
         sat_out_ff   <= calc_clip;
      end
   end

   assign rsp_valid             = out_valid_ff;
   assign rsp_drive             = $signed(drive_out_ff);
   assign rsp_dist_position_out = $signed(dpos_out_ff);
   assign rsp_dist_rate_out     = $signed(drate_out_ff);
   assign rsp_saturated         = sat_out_ff;

   assign out_eq_state = drive_out_ff == state_ff.drive
                      && dpos_out_ff == state_ff.dist_position
                      && drate_out_ff == state_ff.dist_rate;

   `LQRHD_ASSERT_IMPL(a_out_matches_state, out_valid_ff, out_eq_state)
   `LQRHD_ASSERT_IMPL(a_ready_when_out_free, !out_valid_ff, req_ready)
   `LQRHD_ASSERT_IMPL(a_state_holds_idle, !$past(reset) && !$past(stage_fire), $stable(state_ff))

endmodule

[tb/lqr_step_checker.sv]
// Checker for the LQR step block: tracks CSR writes, predicts each result and compares
`timescale 1ns / 1ps
module lqr_step_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic [lqrhd_pkg::DATA_W-1:0]        req_position,
   input  logic [lqrhd_pkg::DATA_W-1:0]        req_rate,
   input  logic                                req_restart,
   input  logic [lqrhd_pkg::DATA_W-1:0]        req_seed_dist_position,
   input  logic [lqrhd_pkg::DATA_W-1:0]        req_seed_dist_rate,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic [lqrhd_pkg::DATA_W-1:0]        rsp_drive,
   input  logic [lqrhd_pkg::DATA_W-1:0]        rsp_dist_position_out,
   input  logic [lqrhd_pkg::DATA_W-1:0]        rsp_dist_rate_out,
   input  logic                                rsp_saturated,
   input  logic                                csr_wen,
   input  logic [lqrhd_pkg::REG_IDX_W-1:0]     csr_index,
   input  logic [lqrhd_pkg::DATA_W-1:0]        csr_wdata,
   output int                                  mismatch_count,
   output int                                  pending_count
);
   import lqrhd_pkg::*;

   typedef struct packed {
      logic [DATA_W-1:0] drive;
      logic [DATA_W-1:0] dist_position;
      logic [DATA_W-1:0] dist_rate;
      logic              saturated;
   } step_result_type;

   localparam longint S32_TOP    = 2147483647;
   localparam longint S32_BOTTOM = -longint'(2147483647) - 1;

   coef_type        coefs;
   state_type       plant;
   step_result_type expected_q[$];
   int              errors = 0;

   // exact product, floor toward minus infinity on the Q8.24 shift
   function automatic longint scale_q24(input logic [DATA_W-1:0] coef,
                                        input logic [DATA_W-1:0] sig);
      longint prod;
      prod = longint'($signed(coef)) * longint'($signed(sig));
      return prod >>> FRAC_SHIFT;
   endfunction

   function automatic sat_type clamp32(input longint v);
      sat_type r;
      r.clip = (v > S32_TOP) || (v < S32_BOTTOM);
      if (r.clip) begin
         r.value = (v > 0) ? SAT_MAX : SAT_MIN;
      end else begin
         r.value = v[DATA_W-1:0];
      end
      return r;
   endfunction

   task automatic predict_step();
      longint          feedback;
      sat_type         nu, nxd, ndxd;
      step_result_type r;
      if (req_restart) begin
         plant.drive         = '0;
         plant.dist_position = req_seed_dist_position;
         plant.dist_rate     = req_seed_dist_rate;
      end
      feedback = scale_q24(coefs.gain_position, req_position)
               + scale_q24(coefs.gain_rate, req_rate)
               + scale_q24(coefs.gain_dist_position, plant.dist_position)
               + scale_q24(coefs.gain_dist_rate, plant.dist_rate)
               + scale_q24(coefs.gain_drive, plant.drive);
      nu   = clamp32(longint'($signed(plant.drive)) - feedback);
      nxd  = clamp32(scale_q24(coefs.diag_coef, plant.dist_position)
                   + scale_q24(coefs.upper_coef, plant.dist_rate));
      ndxd = clamp32(scale_q24(coefs.lower_coef, plant.dist_position)
                   + scale_q24(coefs.diag_coef, plant.dist_rate));
      plant.drive         = nu.value;
      plant.dist_position = nxd.value;
      plant.dist_rate     = ndxd.value;
      r.drive         = nu.value;
      r.dist_position = nxd.value;
      r.dist_rate     = ndxd.value;
      r.saturated     = nu.clip | nxd.clip | ndxd.clip;
      expected_q.push_back(r);
   endtask

   task automatic compare_field(input string field, input logic [DATA_W-1:0] want,
                                input logic [DATA_W-1:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s expected %h actual %h", $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin : track
      step_result_type want;
      if (reset) begin
         coefs           = '0;
         coefs.diag_coef = DIAG_RESET;
         plant           = '0;
         expected_q.delete();
      end else begin
         if (csr_wen) begin
            case (reg_index_type'(csr_index))
               REG_DIAG_COEF:          coefs.diag_coef          = csr_wdata;
               REG_UPPER_COEF:         coefs.upper_coef         = csr_wdata;
               REG_LOWER_COEF:         coefs.lower_coef         = csr_wdata;
               REG_GAIN_POSITION:      coefs.gain_position      = csr_wdata;
               REG_GAIN_RATE:          coefs.gain_rate          = csr_wdata;
               REG_GAIN_DIST_POSITION: coefs.gain_dist_position = csr_wdata;
               REG_GAIN_DIST_RATE:     coefs.gain_dist_rate     = csr_wdata;
               REG_GAIN_DRIVE:         coefs.gain_drive         = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            predict_step();
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               errors++;
               $display("%0t: transaction expected none actual drive %h", $time, rsp_drive);
            end else begin
               want = expected_q.pop_front();
               compare_field("drive", want.drive, rsp_drive);
               compare_field("dist_position_out", want.dist_position, rsp_dist_position_out);
               compare_field("dist_rate_out", want.dist_rate, rsp_dist_rate_out);
               compare_field("saturated", DATA_W'(want.saturated), DATA_W'(rsp_saturated));
            end
         end
      end
      mismatch_count <= errors;
      pending_count  <= expected_q.size();
   end

endmodule

[tb/testbench.sv]
// Testbench top for the LQR step block: clock, reset, stimulus and verdict
`timescale 1ns / 1ps
module testbench;
   import lqrhd_pkg::*;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic signed [DATA_W-1:0] req_position = '0;
   logic signed [DATA_W-1:0] req_rate = '0;
   logic                     req_restart = 1'b0;
   logic signed [DATA_W-1:0] req_seed_dist_position = '0;
   logic signed [DATA_W-1:0] req_seed_dist_rate = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic signed [DATA_W-1:0] rsp_drive;
   logic signed [DATA_W-1:0] rsp_dist_position_out;
   logic signed [DATA_W-1:0] rsp_dist_rate_out;
   logic                     rsp_saturated;
   logic                     csr_wen = 1'b0;
   logic [REG_IDX_W-1:0]     csr_index = '0;
   logic [DATA_W-1:0]        csr_wdata = '0;
   logic                     no_idle = 1'b0;
   int                       mismatch_count;
   int                       pending_count;

   lqr_step_with_harmonic_disturbance dut (.*);

   lqr_step_checker step_check (.*);

   always #2 clock = ~clock;

   always @(posedge clock) begin
      rsp_ready <= no_idle || ($urandom_range(99) >= 37);
   end

   initial begin
      #2_000_000;
      $display("Mismatches found");
      $finish;
   end

   function automatic logic [DATA_W-1:0] spread(input int span);
      return DATA_W'(int'($urandom_range(2 * span)) - span);
   endfunction

   function automatic logic [DATA_W-1:0] pick_signal();
      case ($urandom_range(15))
         0:       return SAT_MAX;
         1:       return SAT_MIN;
         2:       return '0;
         3:       return '1;
         4, 5:    return $urandom();
         default: return spread(1 << 20);
      endcase
   endfunction

   function automatic logic [DATA_W-1:0] wild_coef();
      case ($urandom_range(5))
         0:       return SAT_MAX;
         1:       return SAT_MIN;
         2:       return '0;
         3:       return $urandom();
         default: return spread(1 << 26);
      endcase
   endfunction

   // near-rotation transition with small gains keeps the loop mostly in range
   function automatic coef_type tame_coefs();
      coef_type c;
      c.diag_coef          = DIAG_RESET - $urandom_range(1 << 18);
      c.upper_coef         = spread(1 << 20);
      c.lower_coef         = spread(1 << 20);
      c.gain_position      = spread(1 << 22);
      c.gain_rate          = spread(1 << 22);
      c.gain_dist_position = spread(1 << 22);
      c.gain_dist_rate     = spread(1 << 22);
      c.gain_drive         = spread(1 << 22);
      return c;
   endfunction

   function automatic coef_type wild_coefs();
      coef_type c;
      c.diag_coef          = wild_coef();
      c.upper_coef         = wild_coef();
      c.lower_coef         = wild_coef();
      c.gain_position      = wild_coef();
      c.gain_rate          = wild_coef();
      c.gain_dist_position = wild_coef();
      c.gain_dist_rate     = wild_coef();
      c.gain_drive         = wild_coef();
      return c;
   endfunction

   task automatic send_sample(input logic [DATA_W-1:0] position, input logic [DATA_W-1:0] rate,
                              input logic restart, input logic [DATA_W-1:0] seed_position,
                              input logic [DATA_W-1:0] seed_rate);
      while (!no_idle && $urandom_range(99) < 37) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid              <= 1'b1;
      req_position           <= position;
      req_rate               <= rate;
      req_restart            <= restart;
      req_seed_dist_position <= seed_position;
      req_seed_dist_rate     <= seed_rate;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input reg_index_type idx, input logic [DATA_W-1:0] value);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic load_coefs(input coef_type c);
      write_reg(REG_DIAG_COEF, c.diag_coef);
      write_reg(REG_UPPER_COEF, c.upper_coef);
      write_reg(REG_LOWER_COEF, c.lower_coef);
      write_reg(REG_GAIN_POSITION, c.gain_position);
      write_reg(REG_GAIN_RATE, c.gain_rate);
      write_reg(REG_GAIN_DIST_POSITION, c.gain_dist_position);
      write_reg(REG_GAIN_DIST_RATE, c.gain_dist_rate);
      write_reg(REG_GAIN_DRIVE, c.gain_drive);
      csr_wen <= 1'b0;
   endtask

   initial begin
      int n;
      int phase;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset coefficients: identity transition, no feedback
      send_sample(SAT_MAX, SAT_MIN, 1'b1, SAT_MAX, SAT_MIN);
      send_sample(SAT_MIN, SAT_MAX, 1'b0, '1, '0);
      send_sample(32'h0000_0001, '1, 1'b1, '0, '1);
      wait_idle();

      // largest coefficients, mixed signs: drive and disturbance clip
      load_coefs('{SAT_MAX, SAT_MIN, SAT_MAX, SAT_MAX, SAT_MIN, SAT_MAX, SAT_MIN, SAT_MAX});
      send_sample(SAT_MAX, SAT_MAX, 1'b1, SAT_MAX, SAT_MAX);
      send_sample(SAT_MIN, SAT_MIN, 1'b0, SAT_MIN, SAT_MIN);
      send_sample(SAT_MAX, SAT_MIN, 1'b0, '0, '0);
      send_sample('0, '0, 1'b1, SAT_MIN, SAT_MIN);
      send_sample('0, '0, 1'b0, SAT_MAX, SAT_MAX);
      send_sample(SAT_MIN, SAT_MAX, 1'b0, '1, '1);
      wait_idle();

      load_coefs('{SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN});
      send_sample(SAT_MAX, SAT_MAX, 1'b1, SAT_MAX, SAT_MIN);
      send_sample(SAT_MIN, SAT_MIN, 1'b0, '0, '0);
      send_sample('1, 32'h0000_0001, 1'b0, '0, '0);
      send_sample('0, '0, 1'b1, SAT_MAX, SAT_MAX);
      wait_idle();

      // half and unit gains: rounding of negative products toward minus infinity
      load_coefs('{32'h0080_0000, 32'h0100_0000, 32'hFF00_0000, 32'h0080_0000,
                   32'hFF80_0000, 32'h0100_0000, 32'h0000_0001, 32'hFFFF_FFFF});
      send_sample('1, 32'h0000_0001, 1'b1, '1, 32'h0000_0001);
      send_sample(32'h0000_0001, '1, 1'b0, '0, '0);
      send_sample(32'h0001_0000, 32'hFFFF_0000, 1'b0, '0, '0);
      send_sample(32'hFFFF_FFFD, 32'h0000_0003, 1'b0, '0, '0);
      send_sample('0, '0, 1'b1, SAT_MAX, SAT_MIN);

      for (phase = 0; phase < 8; phase++) begin
         wait_idle();
         load_coefs((phase % 2 == 0) ? tame_coefs() : wild_coefs());
         no_idle <= (phase == 2);
         send_sample(pick_signal(), pick_signal(), 1'b1, pick_signal(), pick_signal());
         for (n = 1; n < 112; n++) begin
            send_sample(pick_signal(), pick_signal(), $urandom_range(99) < 4,
                        pick_signal(), pick_signal());
         end
      end
      wait_idle();
      repeat (8) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
